// ===== rtl/core/nabs_pkg.sv =====
// ----------------------------------------------------------------------------
// nabs_pkg
// Types and constants shared by the null-aware bilinear sampler.
// ----------------------------------------------------------------------------
package nabs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SCALE_SHIFT = 24 - FRAC_BITS;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEST_EDGE  = 3'd0,
        CFG_NORTH_EDGE = 3'd1,
        CFG_INV_EW_RES = 3'd2,
        CFG_INV_NS_RES = 3'd3,
        CFG_ROWS_IN_USE = 3'd4,
        CFG_COLS_IN_USE = 3'd5
    } cfg_reg_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
        logic signed [31:0] cell_value;
        logic               cell_is_null;
        logic signed [39:0] point_x;
        logic signed [39:0] point_y;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_is_null;
    } out_word_t;

endpackage

// ===== rtl/core/null_aware_bilinear_sampler_core.sv =====
// ----------------------------------------------------------------------------
// null_aware_bilinear_sampler_core
// Raster store with null-aware bilinear sampling and renormalized weights.
// ----------------------------------------------------------------------------
// Takes one word per cycle, load or sample, and returns one word for each
// sample, in the order accepted. The grid sits in four memory banks
// split by row and column parity, so all four neighbors are read in the same
// cycle; loads write the same banks at the same stage, so a sample sees every
// load accepted before it. The final division is a 16-stage pipeline that
// resolves two quotient bits per stage. The whole pipeline stalls while a
// result waits on m_ready. Cells in use must be loaded before they are
// sampled.
module null_aware_bilinear_sampler_core
    import nabs_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_word
);

    localparam int HR         = (MAX_ROWS + 1) / 2;
    localparam int HC         = (MAX_COLS + 1) / 2;
    localparam int BANK_DEPTH = HR * HC;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int HRW        = (HR > 1) ? $clog2(HR) : 1;
    localparam int HCW        = (HC > 1) ? $clog2(HC) : 1;
    localparam int DIV_STAGES = 16;
    localparam int DIV_STEP   = 32 / DIV_STAGES;
    localparam int QW         = 56 - SCALE_SHIFT + 1;

    typedef struct packed {
        logic               command;
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
        logic signed [31:0] cell_value;
        logic               cell_is_null;
    } ld_t;

    // configuration
    logic signed [39:0] west_reg, north_reg;
    logic [31:0]        inv_ew_reg, inv_ns_reg;
    logic [8:0]         rows_reg, cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            west_reg   <= '0;
            north_reg  <= '0;
            inv_ew_reg <= 32'd65536;
            inv_ns_reg <= 32'd65536;
            rows_reg   <= 9'd256;
            cols_reg   <= 9'd256;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_WEST_EDGE:   west_reg   <= cfg_wdata;
                CFG_NORTH_EDGE:  north_reg  <= cfg_wdata;
                CFG_INV_EW_RES:  inv_ew_reg <= cfg_wdata[31:0];
                CFG_INV_NS_RES:  inv_ns_reg <= cfg_wdata[31:0];
                CFG_ROWS_IN_USE: rows_reg   <= cfg_wdata[8:0];
                CFG_COLS_IN_USE: cols_reg   <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // S1: offsets from grid edges
    logic               st1_valid_reg;
    ld_t                st1_ld_reg;
    logic signed [40:0] st1_dx_reg, st1_dy_reg;

    // S2: sign and magnitude
    logic        st2_valid_reg;
    ld_t         st2_ld_reg;
    logic        st2_xneg_reg, st2_yneg_reg;
    logic [40:0] st2_xmag_reg, st2_ymag_reg;

    // S3: partial products
    logic        st3_valid_reg;
    ld_t         st3_ld_reg;
    logic        st3_xneg_reg, st3_yneg_reg;
    logic [63:0] st3_xplo_reg, st3_yplo_reg;
    logic [40:0] st3_xphi_reg, st3_yphi_reg;

    // S4: combined product
    logic        st4_valid_reg;
    ld_t         st4_ld_reg;
    logic        st4_xneg_reg, st4_yneg_reg, st4_xsat_reg, st4_ysat_reg;
    logic [55:0] st4_xmag_reg, st4_ymag_reg;

    // S5: floored and clamped magnitude
    logic        st5_valid_reg;
    ld_t         st5_ld_reg;
    logic        st5_xneg_reg, st5_yneg_reg;
    logic [40:0] st5_xq_reg, st5_yq_reg;

    // S6: cell index and fraction
    logic               st6_valid_reg;
    ld_t                st6_ld_reg;
    logic signed [26:0] st6_c0_reg, st6_r0_reg;
    logic [15:0]        st6_tc_reg, st6_tr_reg;

    // S7: weights, neighbor checks, bank addresses
    logic          st7_valid_reg, st7_sample_reg;
    logic [16:0]   st7_w_reg [4];
    logic [1:0]    st7_rok_reg, st7_cok_reg;
    logic          st7_rpar_reg, st7_cpar_reg;
    logic [AW-1:0] st7_addr_reg [4];
    logic          st7_we_reg;
    logic [1:0]    st7_wbank_reg;
    logic [AW-1:0] st7_waddr_reg;
    logic [32:0]   st7_wdata_reg;

    // S8: memory read
    logic        st8_valid_reg;
    logic [16:0] st8_w_reg [4];
    logic [1:0]  st8_rok_reg, st8_cok_reg;
    logic        st8_rpar_reg, st8_cpar_reg;
    logic [32:0] st8_rd_reg [4];

    // S9: weighted products
    logic               st9_valid_reg;
    logic signed [49:0] st9_prod_reg [4];
    logic [16:0]        st9_w_reg [4];

    // S10: sums
    logic               st10_valid_reg;
    logic signed [51:0] st10_sum_reg;
    logic [16:0]        st10_wsum_reg;

    // divider stages, index 0 is the setup stage
    logic        dv_valid_reg [DIV_STAGES+1];
    logic        dv_neg_reg   [DIV_STAGES+1];
    logic        dv_null_reg  [DIV_STAGES+1];
    logic [16:0] dv_wsum_reg  [DIV_STAGES+1];
    logic [16:0] dv_rem_reg   [DIV_STAGES+1];
    logic [31:0] dv_dq_reg    [DIV_STAGES+1];

    out_word_t m_word_reg;

    // ---------------- valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
            st3_valid_reg  <= 1'b0;
            st4_valid_reg  <= 1'b0;
            st5_valid_reg  <= 1'b0;
            st6_valid_reg  <= 1'b0;
            st7_valid_reg  <= 1'b0;
            st8_valid_reg  <= 1'b0;
            st9_valid_reg  <= 1'b0;
            st10_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (en) begin
            st1_valid_reg  <= s_valid;
            st2_valid_reg  <= st1_valid_reg;
            st3_valid_reg  <= st2_valid_reg;
            st4_valid_reg  <= st3_valid_reg;
            st5_valid_reg  <= st4_valid_reg;
            st6_valid_reg  <= st5_valid_reg;
            st7_valid_reg  <= st6_valid_reg;
            st8_valid_reg  <= st7_valid_reg && st7_sample_reg;
            st9_valid_reg  <= st8_valid_reg;
            st10_valid_reg <= st9_valid_reg;
            m_valid_reg    <= dv_valid_reg[DIV_STAGES];
        end
    end

    // ---------------- S1 .. S6
    logic [63:0]        xplo_next, yplo_next;
    logic [40:0]        xphi_next, yphi_next;
    logic [41:0]        xhi_next, yhi_next;
    logic [QW-1:0]      xq_full, yq_full;
    logic [40:0]        xq_next, yq_next;
    logic signed [42:0] fx_next, fy_next;

    localparam logic [QW-1:0] SAT_LIM = QW'(64'd1 << 40);

    always_comb begin
        xplo_next = 64'(st2_xmag_reg[31:0]) * 64'(inv_ew_reg);
        yplo_next = 64'(st2_ymag_reg[31:0]) * 64'(inv_ns_reg);
        xphi_next = 41'(st2_xmag_reg[40:32]) * 41'(inv_ew_reg);
        yphi_next = 41'(st2_ymag_reg[40:32]) * 41'(inv_ns_reg);
        xhi_next  = 42'(st3_xphi_reg) + 42'(st3_xplo_reg[63:32]);
        yhi_next  = 42'(st3_yphi_reg) + 42'(st3_yplo_reg[63:32]);
        xq_full   = QW'(st4_xmag_reg[55:SCALE_SHIFT])
                  + QW'(st4_xneg_reg && (st4_xmag_reg[SCALE_SHIFT-1:0] != '0));
        yq_full   = QW'(st4_ymag_reg[55:SCALE_SHIFT])
                  + QW'(st4_yneg_reg && (st4_ymag_reg[SCALE_SHIFT-1:0] != '0));
        xq_next   = (st4_xsat_reg || xq_full > SAT_LIM) ? 41'(SAT_LIM) : xq_full[40:0];
        yq_next   = (st4_ysat_reg || yq_full > SAT_LIM) ? 41'(SAT_LIM) : yq_full[40:0];
        fx_next   = (st5_xneg_reg ? -$signed({2'b00, st5_xq_reg}) : $signed({2'b00, st5_xq_reg}))
                  - 43'(64'd1 << (FRAC_BITS - 1));
        fy_next   = (st5_yneg_reg ? -$signed({2'b00, st5_yq_reg}) : $signed({2'b00, st5_yq_reg}))
                  - 43'(64'd1 << (FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_ld_reg   <= '{s_word.command, s_word.cell_row, s_word.cell_col,
                              s_word.cell_value, s_word.cell_is_null};
            st1_dx_reg   <= 41'(s_word.point_x) - 41'(west_reg);
            st1_dy_reg   <= 41'(north_reg) - 41'(s_word.point_y);

            st2_ld_reg   <= st1_ld_reg;
            st2_xneg_reg <= st1_dx_reg[40];
            st2_yneg_reg <= st1_dy_reg[40];
            st2_xmag_reg <= st1_dx_reg[40] ? 41'(-st1_dx_reg) : 41'(st1_dx_reg);
            st2_ymag_reg <= st1_dy_reg[40] ? 41'(-st1_dy_reg) : 41'(st1_dy_reg);

            st3_ld_reg   <= st2_ld_reg;
            st3_xneg_reg <= st2_xneg_reg;
            st3_yneg_reg <= st2_yneg_reg;
            st3_xplo_reg <= xplo_next;
            st3_yplo_reg <= yplo_next;
            st3_xphi_reg <= xphi_next;
            st3_yphi_reg <= yphi_next;

            st4_ld_reg   <= st3_ld_reg;
            st4_xneg_reg <= st3_xneg_reg;
            st4_yneg_reg <= st3_yneg_reg;
            st4_xsat_reg <= xhi_next[41:24] != '0;
            st4_ysat_reg <= yhi_next[41:24] != '0;
            st4_xmag_reg <= {xhi_next[23:0], st3_xplo_reg[31:0]};
            st4_ymag_reg <= {yhi_next[23:0], st3_yplo_reg[31:0]};

            st5_ld_reg   <= st4_ld_reg;
            st5_xneg_reg <= st4_xneg_reg;
            st5_yneg_reg <= st4_yneg_reg;
            st5_xq_reg   <= xq_next;
            st5_yq_reg   <= yq_next;

            st6_ld_reg   <= st5_ld_reg;
            st6_c0_reg   <= fx_next[42:FRAC_BITS];
            st6_r0_reg   <= fy_next[42:FRAC_BITS];
            st6_tc_reg   <= fx_next[FRAC_BITS-1:0];
            st6_tr_reg   <= fy_next[FRAC_BITS-1:0];
        end
    end

    // ---------------- S7
    logic [16:0]        omr, omc;
    logic [33:0]        wp [4];
    logic signed [27:0] r0x, c0x, r1x, c1x, nr_lim, nc_lim;
    logic signed [27:0] rsel [2];
    logic signed [27:0] csel [2];
    logic [1:0]         rok_next, cok_next;
    logic [AW-1:0]      addr_next [4];
    logic               ld_in_range;

    always_comb begin
        omr   = 17'(64'd1 << FRAC_BITS) - 17'(st6_tr_reg);
        omc   = 17'(64'd1 << FRAC_BITS) - 17'(st6_tc_reg);
        wp[0] = 34'(omr) * 34'(omc);
        wp[1] = 34'(omr) * 34'(st6_tc_reg);
        wp[2] = 34'(st6_tr_reg) * 34'(omc);
        wp[3] = 34'(st6_tr_reg) * 34'(st6_tc_reg);
        r0x   = 28'(st6_r0_reg);
        c0x   = 28'(st6_c0_reg);
        r1x   = r0x + 28'sd1;
        c1x   = c0x + 28'sd1;
        nr_lim = (32'(rows_reg) > 32'(MAX_ROWS)) ? 28'(MAX_ROWS) : $signed(28'(rows_reg));
        nc_lim = (32'(cols_reg) > 32'(MAX_COLS)) ? 28'(MAX_COLS) : $signed(28'(cols_reg));
        rok_next[0] = (r0x >= 0) && (r0x < nr_lim);
        rok_next[1] = (r1x >= 0) && (r1x < nr_lim);
        cok_next[0] = (c0x >= 0) && (c0x < nc_lim);
        cok_next[1] = (c1x >= 0) && (c1x < nc_lim);
        for (int p = 0; p < 2; p++) begin
            rsel[p] = (r0x[0] == p[0]) ? r0x : r1x;
            csel[p] = (c0x[0] == p[0]) ? c0x : c1x;
        end
        for (int b = 0; b < 4; b++) begin
            addr_next[b] = AW'(32'(rsel[b/2][HRW:1]) * 32'(HC) + 32'(csel[b%2][HCW:1]));
        end
        ld_in_range = (32'(st6_ld_reg.cell_row) < 32'(MAX_ROWS))
                   && (32'(st6_ld_reg.cell_col) < 32'(MAX_COLS));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_sample_reg <= st6_ld_reg.command == CMD_SAMPLE;
            for (int k = 0; k < 4; k++) begin
                st7_w_reg[k]    <= wp[k][32:16];
                st7_addr_reg[k] <= addr_next[k];
            end
            st7_rok_reg   <= rok_next;
            st7_cok_reg   <= cok_next;
            st7_rpar_reg  <= st6_r0_reg[0];
            st7_cpar_reg  <= st6_c0_reg[0];
            st7_we_reg    <= st6_valid_reg && (st6_ld_reg.command == CMD_LOAD) && ld_in_range;
            st7_wbank_reg <= {st6_ld_reg.cell_row[0], st6_ld_reg.cell_col[0]};
            st7_waddr_reg <= AW'(32'(st6_ld_reg.cell_row[7:1]) * 32'(HC)
                               + 32'(st6_ld_reg.cell_col[7:1]));
            st7_wdata_reg <= {st6_ld_reg.cell_is_null, st6_ld_reg.cell_value};
        end
    end

    // ---------------- S8: grid banks
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [32:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (en) begin
                if (st7_valid_reg && st7_we_reg && st7_wbank_reg == 2'(b)) begin
                    bank_mem[st7_waddr_reg] <= st7_wdata_reg;
                end
                st8_rd_reg[b] <= bank_mem[st7_addr_reg[b]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st8_w_reg    <= st7_w_reg;
            st8_rok_reg  <= st7_rok_reg;
            st8_cok_reg  <= st7_cok_reg;
            st8_rpar_reg <= st7_rpar_reg;
            st8_cpar_reg <= st7_cpar_reg;
        end
    end

    // ---------------- S9, S10
    logic [1:0]         nb_bank [4];
    logic [32:0]        nb_data [4];
    logic               nb_use  [4];
    logic [18:0]        wsum_full;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nb_bank[k] = {st8_rpar_reg ^ k[1], st8_cpar_reg ^ k[0]};
            nb_data[k] = st8_rd_reg[nb_bank[k]];
            nb_use[k]  = (st8_w_reg[k] != '0) && st8_rok_reg[k/2] && st8_cok_reg[k%2]
                      && !nb_data[k][32];
        end
        wsum_full = 19'(st9_w_reg[0]) + 19'(st9_w_reg[1])
                  + 19'(st9_w_reg[2]) + 19'(st9_w_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                st9_prod_reg[k] <= nb_use[k]
                    ? 50'($signed({1'b0, st8_w_reg[k]}) * $signed(nb_data[k][31:0])) : '0;
                st9_w_reg[k]    <= nb_use[k] ? st8_w_reg[k] : '0;
            end
            st10_sum_reg  <= 52'(st9_prod_reg[0]) + 52'(st9_prod_reg[1])
                           + 52'(st9_prod_reg[2]) + 52'(st9_prod_reg[3]);
            st10_wsum_reg <= wsum_full[16:0];
        end
    end

    // ---------------- divider
    logic [51:0] sum_mag;
    assign sum_mag = st10_sum_reg[51] ? 52'(-st10_sum_reg) : 52'(st10_sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= st10_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_neg_reg[0]  <= st10_sum_reg[51];
            dv_null_reg[0] <= st10_wsum_reg == '0;
            dv_wsum_reg[0] <= st10_wsum_reg;
            dv_rem_reg[0]  <= 17'(sum_mag[47:32]);
            dv_dq_reg[0]   <= sum_mag[31:0];
        end
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        logic [16:0] rem_next;
        logic [31:0] dq_next;
        logic [17:0] trial;

        always_comb begin
            rem_next = dv_rem_reg[i];
            dq_next  = dv_dq_reg[i];
            trial    = '0;
            for (int s = 0; s < DIV_STEP; s++) begin
                trial = {rem_next, dq_next[31]};
                if (trial >= 18'(dv_wsum_reg[i])) begin
                    rem_next = 17'(trial - 18'(dv_wsum_reg[i]));
                    dq_next  = {dq_next[30:0], 1'b1};
                end else begin
                    rem_next = trial[16:0];
                    dq_next  = {dq_next[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_neg_reg[i+1]  <= dv_neg_reg[i];
                dv_null_reg[i+1] <= dv_null_reg[i];
                dv_wsum_reg[i+1] <= dv_wsum_reg[i];
                dv_rem_reg[i+1]  <= rem_next;
                dv_dq_reg[i+1]   <= dq_next;
            end
        end
    end

    // ---------------- output
    logic [31:0] q_mag;
    logic [31:0] q_floor;

    always_comb begin
        q_mag = dv_dq_reg[DIV_STAGES];
        if (!dv_neg_reg[DIV_STAGES]) begin
            q_floor = q_mag;
        end else if (dv_rem_reg[DIV_STAGES] != '0) begin
            q_floor = ~q_mag;
        end else begin
            q_floor = -q_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_word_reg.sample_value   <= dv_null_reg[DIV_STAGES] ? '0 : $signed(q_floor);
            m_word_reg.sample_is_null <= dv_null_reg[DIV_STAGES];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
